[hdl/cta_pkg.sv]
package cta_pkg;

  // Default sizing of the sensor table
  localparam int NUM_SENSORS_DEF     = 38;
  localparam int BYTES_PER_FRAME_DEF = 8;

  // Field widths
  localparam int ID_W      = 29;
  localparam int TEMP_W    = 8;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int PAYLOAD_W = 64;
  localparam int ROW_W     = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // Identifier offsets above base_id
  localparam int LAST_OFFSET = 6;
  localparam int DATA_FRAMES = 5;

  // Register reset values
  localparam logic [ID_W-1:0]     BASE_ID_RST   = '0;
  localparam logic [TEMP_W-1:0]   OVERTEMP_RST  = 8'd65;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd100;
  localparam logic [PERIOD_W-1:0] DELAY_RST     = '0;

  // Neutral values for the running min / max
  localparam logic [TEMP_W-1:0] TEMP_MIN_NONE = '1;
  localparam logic [TEMP_W-1:0] TEMP_MAX_NONE = '0;

  // Register indexes
  localparam logic [1:0] REG_BASE_ID        = 2'd0;
  localparam logic [1:0] REG_OVERTEMP_LIMIT = 2'd1;
  localparam logic [1:0] REG_REQUEST_PERIOD = 2'd2;
  localparam logic [1:0] REG_INITIAL_DELAY  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic                 mode;
    logic [ID_W-1:0]      frame_id;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    now_time;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [TEMP_W-1:0] max_temp;
    logic [TEMP_W-1:0] min_temp;
    logic              request_now;
    logic              error_code;
  } result_t;

  // Control from the sequencer to every lane
  typedef struct packed {
    logic wr_en;
    logic clear_acc;
    logic scan_en;
  } lane_ctrl_t;

  // Partial scan result of one lane
  typedef struct packed {
    logic [TEMP_W-1:0] hi;
    logic [TEMP_W-1:0] lo;
  } lane_res_t;

endpackage

[hdl/cta_lane.sv]
module cta_lane
  import cta_pkg::*;
#(
  parameter int NUM_SENSORS     = NUM_SENSORS_DEF,
  parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF,
  parameter int LANE            = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  lane_ctrl_t        ctrl,
  input  logic [ROW_W-1:0]  wr_row,
  input  logic [TEMP_W-1:0] wr_data,
  output logic [TEMP_W-1:0] head,
  output lane_res_t         res
);

  localparam int ROWS = (NUM_SENSORS + BYTES_PER_FRAME - 1) / BYTES_PER_FRAME;

  // Column of slots LANE, LANE+B, LANE+2B, ...; slots past the table stay zero
  logic [TEMP_W-1:0] col [ROWS];
  lane_res_t         acc;

  // Column store: row write on a data frame, full rotation during the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        col[r] <= '0;
      end
    end else if (ctrl.scan_en) begin
      for (int r = 0; r < ROWS - 1; r++) begin
        col[r] <= col[r+1];
      end
      col[ROWS-1] <= col[0];
    end else if (ctrl.wr_en) begin
      for (int r = 0; r < ROWS; r++) begin
        if ((int'(wr_row) == r) && (r * BYTES_PER_FRAME + LANE < NUM_SENSORS)) begin
          col[r] <= wr_data;
        end
      end
    end
  end

  // Running max and nonzero min over the rotating head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      acc.hi <= TEMP_MAX_NONE;
      acc.lo <= TEMP_MIN_NONE;
    end else if (ctrl.clear_acc) begin
      acc.hi <= TEMP_MAX_NONE;
      acc.lo <= TEMP_MIN_NONE;
    end else if (ctrl.scan_en) begin
      if (col[0] > acc.hi) begin
        acc.hi <= col[0];
      end
      if ((col[0] != '0) && (col[0] < acc.lo)) begin
        acc.lo <= col[0];
      end
    end
  end

  assign head = col[0];
  assign res  = acc;

endmodule

[hdl/cta_merge.sv]
module cta_merge
  import cta_pkg::*;
#(
  parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF
) (
  input  lane_res_t         lanes [BYTES_PER_FRAME],
  input  logic [TEMP_W-1:0] slot0,
  output lane_res_t         merged
);

  // Combine lane partials; an empty slot 0 pins the minimum to zero
  always_comb begin
    logic [TEMP_W-1:0] hi;
    logic [TEMP_W-1:0] lo;
    hi = TEMP_MAX_NONE;
    lo = TEMP_MIN_NONE;
    for (int j = 0; j < BYTES_PER_FRAME; j++) begin
      if (lanes[j].hi > hi) begin
        hi = lanes[j].hi;
      end
      if (lanes[j].lo < lo) begin
        lo = lanes[j].lo;
      end
    end
    merged.hi = hi;
    merged.lo = (slot0 == '0) ? '0 : lo;
  end

endmodule

[hdl/cell_temperature_aggregator_top.sv]
// Cell temperature aggregator. Each transfer on the item channel is either a
// received CAN frame (mode 0) or a time tick (mode 1), and each gives exactly
// one result. A frame 1 to 5 ids above base_id writes its payload bytes into
// one row of the sensor table; 6 above is accepted without a write. Every
// accepted frame rescans the table: one lane per payload byte holds a column
// of the table and rotates it past a max / nonzero-min unit, one row per
// cycle, through the scan state for the row count of the lane columns and
// then the merge state. Ticks and out-of-range frames skip the scan and
// load their result register in the cycle of their transfer. The
// overtemperature check on a tick compares the limit with the stored
// maximum. The table is cleared by reset; no clearing pass is needed.
// Registers: base_id at 0x0, overtemp_limit at 0x4, request_period at 0x8,
// initial_delay at 0xC (a write also reloads the next request time).
module cell_temperature_aggregator_top
  import cta_pkg::*;
#(
  parameter int NUM_SENSORS     = NUM_SENSORS_DEF,
  parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int ROWS = (NUM_SENSORS + BYTES_PER_FRAME - 1) / BYTES_PER_FRAME;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Configuration registers
  logic [ID_W-1:0]     base_id;
  logic [TEMP_W-1:0]   overtemp_limit;
  logic [PERIOD_W-1:0] request_period;
  logic [PERIOD_W-1:0] initial_delay;

  // Block state
  state_t            state, state_next;
  logic [RW-1:0]     cnt;
  logic [TEMP_W-1:0] highest;
  logic [TEMP_W-1:0] lowest;
  logic [TIME_W-1:0] next_req_time;
  logic              err_latch;

  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic              item_xfer;
  logic [ID_W:0]     id_diff;
  logic              in_range;
  logic              is_data;
  logic [ROW_W-1:0]  wr_row;
  logic              req;
  logic              err_set;
  logic              result_load;
  result_t           result_next;
  lane_ctrl_t        lane_ctrl;
  lane_res_t         lane_res [BYTES_PER_FRAME];
  lane_res_t         merged;
  logic [TEMP_W-1:0] slot0;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id        <= BASE_ID_RST;
      overtemp_limit <= OVERTEMP_RST;
      request_period <= PERIOD_RST;
      initial_delay  <= DELAY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BASE_ID:        base_id        <= pwdata[ID_W-1:0];
        REG_OVERTEMP_LIMIT: overtemp_limit <= pwdata[TEMP_W-1:0];
        REG_REQUEST_PERIOD: request_period <= pwdata[PERIOD_W-1:0];
        REG_INITIAL_DELAY:  initial_delay  <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BASE_ID:        prdata = DATA_W'(base_id);
      REG_OVERTEMP_LIMIT: prdata = DATA_W'(overtemp_limit);
      REG_REQUEST_PERIOD: prdata = DATA_W'(request_period);
      REG_INITIAL_DELAY:  prdata = DATA_W'(initial_delay);
      default:            prdata = '0;
    endcase
  end

  // Frame id decode, no wrap below base_id
  assign id_diff  = {1'b0, item.frame_id} - {1'b0, base_id};
  assign in_range = !id_diff[ID_W] && (id_diff != '0)
                    && (id_diff <= (ID_W+1)'(LAST_OFFSET));
  assign is_data  = id_diff <= (ID_W+1)'(DATA_FRAMES);
  assign wr_row   = id_diff[ROW_W-1:0] - ROW_W'(1);

  // Tick decode
  assign req     = item.now_time > next_req_time;
  assign err_set = req && (highest > overtemp_limit);

  assign item_xfer = item_valid && item_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_xfer && !item.mode && in_range) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == RW'(ROWS - 1)) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs and control
  always_comb begin
    item_ready          = 1'b0;
    lane_ctrl           = '0;
    result_load         = 1'b0;
    result_next         = '0;
    result_next.max_temp = highest;
    result_next.min_temp = lowest;
    result_next.error_code = err_latch;
    case (state)
      ST_IDLE: begin
        item_ready = !result_valid || result_ready;
        if (item_xfer) begin
          if (item.mode) begin
            result_load             = 1'b1;
            result_next.request_now = req;
            result_next.error_code  = err_latch || err_set;
          end else if (in_range) begin
            lane_ctrl.clear_acc = 1'b1;
            lane_ctrl.wr_en     = is_data;
          end else begin
            result_load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        lane_ctrl.scan_en = 1'b1;
      end
      ST_MERGE: begin
        result_load          = 1'b1;
        result_next.accepted = 1'b1;
        result_next.max_temp = merged.hi;
        result_next.min_temp = merged.lo;
      end
      default: ;
    endcase
  end

  // Sequencer and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        cnt <= cnt + RW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // Scan results, request timer and error latch
  always_ff @(posedge clk) begin
    if (rst) begin
      highest       <= '0;
      lowest        <= '0;
      next_req_time <= TIME_W'(DELAY_RST);
      err_latch     <= 1'b0;
    end else begin
      if (state == ST_MERGE) begin
        highest <= merged.hi;
        lowest  <= merged.lo;
      end
      if (cfg_wr && (cfg_idx == REG_INITIAL_DELAY)) begin
        next_req_time <= TIME_W'(pwdata[PERIOD_W-1:0]);
      end else if (item_xfer && item.mode && req) begin
        next_req_time <= next_req_time + TIME_W'(request_period);
      end
      if (item_xfer && item.mode && err_set) begin
        err_latch <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= result_next;
    end
  end

  // One lane per payload byte
  for (genvar j = 0; j < BYTES_PER_FRAME; j++) begin : g_lane
    if (j == 0) begin : g_head
      cta_lane #(
        .NUM_SENSORS     (NUM_SENSORS),
        .BYTES_PER_FRAME (BYTES_PER_FRAME),
        .LANE            (j)
      ) u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (lane_ctrl),
        .wr_row  (wr_row),
        .wr_data (item.payload[TEMP_W*j +: TEMP_W]),
        .head    (slot0),
        .res     (lane_res[j])
      );
    end else begin : g_body
      cta_lane #(
        .NUM_SENSORS     (NUM_SENSORS),
        .BYTES_PER_FRAME (BYTES_PER_FRAME),
        .LANE            (j)
      ) u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (lane_ctrl),
        .wr_row  (wr_row),
        .wr_data (item.payload[TEMP_W*j +: TEMP_W]),
        .head    (),
        .res     (lane_res[j])
      );
    end
  end

  cta_merge #(
    .BYTES_PER_FRAME (BYTES_PER_FRAME)
  ) u_merge (
    .lanes  (lane_res),
    .slot0  (slot0),
    .merged (merged)
  );

endmodule

[sim/tb_cell_temperature_aggregator_top.sv]
`timescale 1ns / 100ps

module tb_cell_temperature_aggregator_top;
  import cta_pkg::*;

  localparam int          NUM_TEMPS   = NUM_SENSORS_DEF;
  localparam int          FRAME_BYTES = BYTES_PER_FRAME_DEF;
  localparam int          LIMIT       = 2_000_000;
  localparam int          SHOWN       = 10;
  localparam logic        MODE_FRAME  = 1'b0;
  localparam logic        MODE_TICK   = 1'b1;
  localparam logic [31:0] TIME_MAX    = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0] ID_MAX  = '1;

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  item_t             item;
  logic              result_valid;
  logic              result_ready;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cell_temperature_aggregator_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register shadows
  logic [ID_W-1:0]     cfg_base   = BASE_ID_RST;
  logic [TEMP_W-1:0]   cfg_limit  = OVERTEMP_RST;
  logic [PERIOD_W-1:0] cfg_period = PERIOD_RST;
  logic [PERIOD_W-1:0] cfg_delay  = DELAY_RST;

  // Predicted block state
  logic [TEMP_W-1:0] temps [NUM_TEMPS];
  logic [TEMP_W-1:0] hi_temp       = '0;
  logic [TEMP_W-1:0] lo_temp       = '0;
  logic [TIME_W-1:0] next_req      = 32'(DELAY_RST);
  logic              overtemp_seen = 1'b0;

  // Request time as seen by the stimulus generator, to aim ticks near it
  logic [TIME_W-1:0] plan_next = 32'(DELAY_RST);

  item_t   item_q [$];
  result_t sensor_results_q [$];

  logic item_taken  = 1'b0;
  bit   calm        = 1'b0;
  int   gap_left    = 0;
  int   stall_left  = 0;
  int   cycles      = 0;
  int   mismatches  = 0;
  int   n_items     = 0;
  int   n_results   = 0;
  int   n_accepted  = 0;
  int   n_requests  = 0;

  initial begin
    for (int i = 0; i < NUM_TEMPS; i++) temps[i] = '0;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOWN) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Apply one item to the predicted state and work out its result
  function automatic result_t sensor_update(input item_t it);
    result_t     r;
    logic [31:0] offset;
    int          slot;
    logic [7:0]  v;
    r = '0;
    if (it.mode == MODE_FRAME) begin
      if (it.frame_id > cfg_base) begin
        offset = 32'(it.frame_id) - 32'(cfg_base);
        if (offset <= LAST_OFFSET) begin
          r.accepted = 1'b1;
          if (offset <= DATA_FRAMES) begin
            for (int b = 0; b < FRAME_BYTES; b++) begin
              slot = (int'(offset) - 1) * FRAME_BYTES + b;
              if (slot < NUM_TEMPS) temps[slot] = it.payload[8*b +: 8];
            end
          end
          // rescan: both extremes seeded by slot 0
          hi_temp = temps[0];
          lo_temp = temps[0];
          for (int i = 0; i < NUM_TEMPS; i++) begin
            v = temps[i];
            if (v > hi_temp) hi_temp = v;
            else if (v != 0 && v < lo_temp) lo_temp = v;
          end
        end
      end
    end else if (it.now_time > next_req) begin
      r.request_now = 1'b1;
      next_req = next_req + 32'(cfg_period);
      for (int i = 0; i < NUM_TEMPS; i++)
        if (temps[i] > cfg_limit) overtemp_seen = 1'b1;
    end
    r.max_temp   = hi_temp;
    r.min_temp   = lo_temp;
    r.error_code = overtemp_seen;
    return r;
  endfunction

  // Item driver: changes on the falling edge, holds until the transfer
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && !item_taken)) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        item       <= item_q.pop_front();
        item_valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 15);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Monitor: predict on each input transfer, then check each result transfer
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("cell_temperature_aggregator_top verification failed");
      $finish;
    end else if (!rst) begin
      if (item_valid && item_ready) begin
        sensor_results_q.push_back(sensor_update(item));
        item_taken = 1'b1;
        n_items++;
      end
      if (result_valid && result_ready) begin
        n_results++;
        if (result.accepted) n_accepted++;
        if (result.request_now) n_requests++;
        if (sensor_results_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending: %p", result));
        end else begin
          want = sensor_results_q.pop_front();
          if (result.accepted !== want.accepted || result.max_temp !== want.max_temp ||
              result.min_temp !== want.min_temp ||
              result.request_now !== want.request_now ||
              result.error_code !== want.error_code)
            note_mismatch($sformatf(
              "acc %0b/%0b max %0d/%0d min %0d/%0d req %0b/%0b err %0b/%0b (exp/got)",
              want.accepted, result.accepted, want.max_temp, result.max_temp,
              want.min_temp, result.min_temp, want.request_now, result.request_now,
              want.error_code, result.error_code));
        end
      end
    end
  end

  // Register write followed by a readback of the same register
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE_ID:        cfg_base   = val[ID_W-1:0];
      REG_OVERTEMP_LIMIT: cfg_limit  = val[TEMP_W-1:0];
      REG_REQUEST_PERIOD: cfg_period = val[PERIOD_W-1:0];
      REG_INITIAL_DELAY: begin
        cfg_delay = val[PERIOD_W-1:0];
        next_req  = 32'(val[PERIOD_W-1:0]);
      end
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE_ID:        want = 32'(cfg_base);
      REG_OVERTEMP_LIMIT: want = 32'(cfg_limit);
      REG_REQUEST_PERIOD: want = 32'(cfg_period);
      default:            want = 32'(cfg_delay);
    endcase
    if (prdata !== want)
      note_mismatch($sformatf("register %0d read %0h, expected %0h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [ID_W-1:0] base, input logic [7:0] lim,
                           input logic [15:0] period, input logic [15:0] delay);
    reg_write(REG_BASE_ID, 32'(base));
    reg_write(REG_OVERTEMP_LIMIT, 32'(lim));
    reg_write(REG_REQUEST_PERIOD, 32'(period));
    reg_write(REG_INITIAL_DELAY, 32'(delay));
    plan_next = 32'(delay);
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || item_valid || sensor_results_q.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic push_item(input logic mode, input logic [ID_W-1:0] id,
                           input logic [63:0] data, input logic [31:0] now);
    item_t it;
    it.mode     = mode;
    it.frame_id = id;
    it.payload  = data;
    it.now_time = now;
    item_q.push_back(it);
  endtask

  // Payload bytes lean toward zero, full scale and small values
  function automatic logic [63:0] temp_bytes();
    logic [63:0] d;
    for (int b = 0; b < 8; b++) begin
      case ($urandom_range(0, 7))
        0:       d[8*b +: 8] = 8'h00;
        1:       d[8*b +: 8] = 8'hFF;
        2:       d[8*b +: 8] = 8'($urandom_range(1, 20));
        default: d[8*b +: 8] = 8'($urandom);
      endcase
    end
    return d;
  endfunction

  task automatic push_random(input int count);
    int          pick;
    logic [31:0] now;
    logic [63:0] junk;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      junk = {$urandom, $urandom};
      if (pick < 55) begin
        push_item(MODE_FRAME, cfg_base + ID_W'($urandom_range(1, 6)), temp_bytes(),
                  $urandom);
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0:       now = plan_next + 32'($urandom_range(0, 2)) - 32'd1;
          1:       now = plan_next + 32'($urandom_range(0, 2 * int'(cfg_period) + 2));
          default: now = $urandom;
        endcase
        if (now > plan_next) plan_next = plan_next + 32'(cfg_period);
        push_item(MODE_TICK, junk[ID_W-1:0], {$urandom, $urandom}, now);
      end else begin
        case ($urandom_range(0, 3))
          0:       push_item(MODE_FRAME, junk[ID_W-1:0], temp_bytes(), $urandom);
          1:       push_item(MODE_FRAME, cfg_base, temp_bytes(), $urandom);
          2:       push_item(MODE_FRAME, cfg_base - ID_W'(1), temp_bytes(), $urandom);
          default: push_item(MODE_FRAME, cfg_base + ID_W'($urandom_range(7, 12)),
                             temp_bytes(), $urandom);
        endcase
      end
    end
    wait_idle();
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset register values
    push_item(MODE_TICK, '0, '0, 32'd0);        // equal to next time: no request
    push_item(MODE_TICK, ID_MAX, '1, 32'd1);     // first request
    push_item(MODE_FRAME, '0, '1, '0);           // offset zero
    push_item(MODE_FRAME, 29'd1, 64'h0102_0304_0506_0741, '1);  // slot 0 at the limit
    push_item(MODE_TICK, '0, '0, 32'd101);       // request, no overtemperature
    push_item(MODE_TICK, '0, '0, 32'd200);
    push_item(MODE_FRAME, 29'd2, '0, '0);
    push_item(MODE_FRAME, 29'd5, 64'hFFEE_DDCC_BBAA_9988, '0);  // tail bytes dropped
    push_item(MODE_FRAME, 29'd6, '1, '0);        // accepted, stores nothing
    push_item(MODE_FRAME, 29'd7, '1, '0);
    push_item(MODE_FRAME, ID_MAX, '1, '0);
    push_item(MODE_FRAME, 29'd1, 64'h2030_4050_6070_8000, '0);  // empty slot 0
    push_item(MODE_FRAME, 29'd1, 64'h0000_0000_0000_0042, '0);  // just over the limit
    push_item(MODE_TICK, '0, '0, TIME_MAX);      // latches overtemperature
    push_item(MODE_TICK, '0, '0, 32'd0);
    push_item(MODE_FRAME, 29'd3, 64'h0101_0101_0101_0101, '0);
    push_item(MODE_FRAME, 29'd4, '1, '0);
    wait_idle();

    // Base near the top of the id range, limit zero, shortest period
    configure(ID_MAX - ID_W'(6), 8'd0, 16'd1, 16'd0);
    push_random(300);

    // Nothing can be accepted; zero period keeps the request time fixed
    configure(ID_MAX, 8'hFF, 16'd0, 16'hFFFF);
    push_random(120);

    // Longest period, a run of ticks at the top of the time range
    configure(ID_W'($urandom), 8'($urandom), 16'hFFFF, 16'hFFF0);
    calm = 1'b1;
    for (int n = 0; n < 30; n++) push_item(MODE_TICK, '0, '0, TIME_MAX);
    wait_idle();
    calm = 1'b0;
    push_random(100);

    // Small base, mid limit, random timing; the tail runs without idling
    configure(ID_W'(5), 8'd100, 16'($urandom_range(1, 65535)), 16'($urandom));
    push_random(150);
    calm = 1'b1;
    push_random(150);
    repeat (20) @(posedge clk);

    while (sensor_results_q.size() != 0)
      note_mismatch($sformatf("no result for expected %p", sensor_results_q.pop_front()));
    $display("%0d item transfers, %0d results checked over 5 register settings",
             n_items, n_results);
    $display("%0d frames accepted, %0d requests raised, %0d mismatches",
             n_accepted, n_requests, mismatches);
    if (mismatches == 0) begin
      $display("cell_temperature_aggregator_top verification clean");
    end else begin
      $display("cell_temperature_aggregator_top verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cta_pkg.sv
hdl/cta_lane.sv
hdl/cta_merge.sv
hdl/cell_temperature_aggregator_top.sv
sim/tb_cell_temperature_aggregator_top.sv
